@@ sv/hrt_pkg.sv @@
// ----------------------------------------------------------------------------
// hrt_pkg
// Shared types and constants of the hashed reply tracker table.
// ----------------------------------------------------------------------------
`default_nettype none

package hrt_pkg;

  // slot count: a power of two, the home slot is the low bits of the hash
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned LIVE_W      = $clog2(TABLE_SLOTS + 1);

  localparam logic [63:0] HASH_MUL   = 64'hff51afd7ed558ccd;
  localparam int unsigned HASH_SHIFT = 33;

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_TAKE   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  mark;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] age;
  } slot_t;

  localparam int unsigned SLOT_BITS = $bits(slot_t);

  typedef enum logic [2:0] {
    WR_NONE,
    WR_PUT_POS,
    WR_PUT_TOMB,
    WR_PUT_LOW,
    WR_TOMB_POS,
    WR_WIPE
  } wr_sel_t;

  typedef struct packed {
    logic       load;
    logic       mul0;
    logic       mul1;
    logic       mul2;
    logic       home_load;
    logic       probe_next;
    logic       tomb_capture;
    logic       scan;
    logic       ev_init;
    logic       ev_next;
    logic       ev_capture;
    logic       clr_next;
    wr_sel_t    wr;
    logic       age_inc;
    logic       age_zero;
    logic       live_inc;
    logic       live_dec;
    logic       live_zero;
    logic       res_ok;
    logic       res_take;
    logic       push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       key_zero;
    logic       val_zero;
    logic [1:0] mark;
    logic       key_match;
    logic       n_last;
    logic       have_tomb;
    logic       ev_last;
    logic       clr_last;
    logic       live_one;
    logic       out_busy;
  } st_t;

endpackage

`default_nettype wire

@@ sv/hrt_ram.sv @@
// ----------------------------------------------------------------------------
// hrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/hrt_dp.sv @@
// ----------------------------------------------------------------------------
// hrt_dp
// Datapath: request registers, hash multiplier, probe and scan pointers,
// slot store, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrt_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [1:0]     func,
  input  wire logic [63:0]    lookup_key,
  input  wire logic [63:0]    entry_value,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic                ok,
  output logic      [63:0]    taken_value,
  input  wire hrt_pkg::cmd_t  cmd,
  output hrt_pkg::st_t        st
);

  localparam logic [hrt_pkg::SLOT_W-1:0] LAST_SLOT = hrt_pkg::SLOT_W'(hrt_pkg::TABLE_SLOTS - 1);

  logic [1:0]                  func_r;
  logic [63:0]                 key_r;
  logic [63:0]                 val_r;
  logic [63:0]                 acc;
  logic [hrt_pkg::SLOT_W-1:0]  pos;
  logic [hrt_pkg::SLOT_W-1:0]  n;
  logic [hrt_pkg::SLOT_W-1:0]  tomb;
  logic                        have_tomb;
  logic [hrt_pkg::SLOT_W-1:0]  scan_idx;
  logic [hrt_pkg::SLOT_W-1:0]  low;
  logic [63:0]                 low_age;
  logic [hrt_pkg::SLOT_W-1:0]  clr_idx;
  logic [hrt_pkg::LIVE_W-1:0]  live;
  logic [63:0]                 age;
  logic                        res_ok;
  logic [63:0]                 res_taken;

  logic [63:0]                 mixed;
  logic [31:0]                 op_a;
  logic [31:0]                 op_b;
  logic [63:0]                 prod;
  logic [63:0]                 hashed;
  logic [63:0]                 age_plus;
  logic [hrt_pkg::SLOT_W-1:0]  pos_inc;

  logic                        we;
  logic [hrt_pkg::SLOT_W-1:0]  waddr;
  hrt_pkg::slot_t              wdata;
  logic [hrt_pkg::SLOT_W-1:0]  raddr;
  hrt_pkg::slot_t              rdata;

  // k ^ (k >> 33), split over three 32x32 partial products (low 64 bits only)
  assign mixed = key_r ^ (key_r >> hrt_pkg::HASH_SHIFT);

  always_comb begin
    op_a = mixed[31:0];
    op_b = hrt_pkg::HASH_MUL[31:0];
    if (cmd.mul1) begin
      op_b = hrt_pkg::HASH_MUL[63:32];
    end else if (cmd.mul2) begin
      op_a = mixed[63:32];
    end
  end

  assign prod = 64'(op_a) * 64'(op_b);

  // final mix; home slot is its low bits
  assign hashed = acc ^ (acc >> hrt_pkg::HASH_SHIFT);

  assign pos_inc  = (pos == LAST_SLOT) ? '0 : pos + 1'b1;
  assign age_plus = age + 64'd1;

  // store port
  always_comb begin
    we    = 1'b1;
    waddr = pos;
    wdata = '{mark: hrt_pkg::MARK_LIVE, key: key_r, value: val_r, age: age_plus};
    unique case (cmd.wr)
      hrt_pkg::WR_NONE:     we = 1'b0;
      hrt_pkg::WR_PUT_POS:  waddr = pos;
      hrt_pkg::WR_PUT_TOMB: waddr = tomb;
      hrt_pkg::WR_PUT_LOW:  waddr = low;
      hrt_pkg::WR_TOMB_POS: wdata = '{mark: hrt_pkg::MARK_TOMB, key: '0, value: '0, age: '0};
      hrt_pkg::WR_WIPE: begin
        waddr = clr_idx;
        wdata = '0;
      end
      default:              we = 1'b0;
    endcase
  end

  assign raddr = cmd.scan ? scan_idx : pos;

  hrt_ram #(
    .WIDTH(hrt_pkg::SLOT_BITS),
    .DEPTH(hrt_pkg::TABLE_SLOTS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= func;
      key_r     <= lookup_key;
      val_r     <= entry_value;
      res_ok    <= 1'b0;
      res_taken <= '0;
      have_tomb <= 1'b0;
    end
    if (cmd.mul0) begin
      acc <= prod;
    end else if (cmd.mul1 || cmd.mul2) begin
      acc <= acc + {prod[31:0], 32'd0};
    end
    if (cmd.home_load) begin
      pos <= hashed[hrt_pkg::SLOT_W-1:0];
      n   <= '0;
    end else if (cmd.probe_next) begin
      pos <= pos_inc;
      n   <= n + 1'b1;
    end
    if (cmd.tomb_capture) begin
      tomb      <= pos;
      have_tomb <= 1'b1;
    end
    if (cmd.ev_init) begin
      scan_idx <= '0;
    end else if (cmd.ev_next) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.ev_capture && (scan_idx == '0 || rdata.age < low_age)) begin
      low     <= scan_idx;
      low_age <= rdata.age;
    end
    if (cmd.res_ok) begin
      res_ok <= 1'b1;
    end
    if (cmd.res_take) begin
      res_ok    <= 1'b1;
      res_taken <= rdata.value;
    end
    if (cmd.push) begin
      ok          <= res_ok;
      taken_value <= res_taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      live      <= '0;
      age       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_next) begin
        clr_idx <= (clr_idx == LAST_SLOT) ? '0 : clr_idx + 1'b1;
      end
      if (cmd.live_zero) begin
        live <= '0;
      end else if (cmd.live_inc) begin
        live <= live + 1'b1;
      end else if (cmd.live_dec && live != '0) begin
        live <= live - 1'b1;
      end
      if (cmd.age_zero) begin
        age <= '0;
      end else if (cmd.age_inc) begin
        age <= age_plus;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.func      = func_r;
  assign st.key_zero  = (key_r == '0);
  assign st.val_zero  = (val_r == '0);
  assign st.mark      = rdata.mark;
  assign st.key_match = (rdata.key == key_r);
  assign st.n_last    = (n == LAST_SLOT);
  assign st.have_tomb = have_tomb;
  assign st.ev_last   = (scan_idx == LAST_SLOT);
  assign st.clr_last  = (clr_idx == LAST_SLOT);
  assign st.live_one  = (live == hrt_pkg::LIVE_W'(1));
  assign st.out_busy  = out_valid && !out_ready;

endmodule

`default_nettype wire

@@ sv/hrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// hrt_ctrl
// Controller: sequences hashing, probing, eviction scan and clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hrt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hrt_pkg::st_t  st,
  output hrt_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DEC,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MIX,
    S_PRB_RD,
    S_PRB_CHK,
    S_EV_RD,
    S_EV_CHK,
    S_EV_PUT,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   clr_resp;
  logic   clr_resp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_resp <= 1'b0;
    end else begin
      state    <= state_next;
      clr_resp <= clr_resp_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.wr        = hrt_pkg::WR_NONE;
    state_next    = state;
    clr_resp_next = clr_resp;
    unique case (state)
      S_CLR: begin
        cmd.wr       = hrt_pkg::WR_WIPE;
        cmd.clr_next = 1'b1;
        if (st.clr_last) begin
          state_next    = clr_resp ? S_DONE : S_IDLE;
          clr_resp_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        priority if (st.func == hrt_pkg::FUNC_CLEAR) begin
          cmd.live_zero = 1'b1;
          cmd.age_zero  = 1'b1;
          clr_resp_next = 1'b1;
          state_next    = S_CLR;
        end else if (st.func == hrt_pkg::FUNC_RECORD && !st.key_zero && !st.val_zero) begin
          state_next = S_MUL0;
        end else if (st.func == hrt_pkg::FUNC_TAKE && !st.key_zero) begin
          state_next = S_MUL0;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.home_load = 1'b1;
        state_next    = S_PRB_RD;
      end
      S_PRB_RD: begin
        state_next = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        if (st.func == hrt_pkg::FUNC_RECORD) begin
          priority if (st.mark == hrt_pkg::MARK_LIVE && st.key_match) begin
            cmd.wr      = hrt_pkg::WR_PUT_POS;
            cmd.age_inc = 1'b1;
            cmd.res_ok  = 1'b1;
            state_next  = S_DONE;
          end else if (st.mark == hrt_pkg::MARK_EMPTY) begin
            cmd.wr       = st.have_tomb ? hrt_pkg::WR_PUT_TOMB : hrt_pkg::WR_PUT_POS;
            cmd.age_inc  = 1'b1;
            cmd.live_inc = 1'b1;
            cmd.res_ok   = 1'b1;
            state_next   = S_DONE;
          end else if (st.n_last) begin
            if (st.have_tomb || st.mark == hrt_pkg::MARK_TOMB) begin
              cmd.wr       = st.have_tomb ? hrt_pkg::WR_PUT_TOMB : hrt_pkg::WR_PUT_POS;
              cmd.age_inc  = 1'b1;
              cmd.live_inc = 1'b1;
              cmd.res_ok   = 1'b1;
              state_next   = S_DONE;
            end else begin
              cmd.ev_init = 1'b1;
              state_next  = S_EV_RD;
            end
          end else begin
            cmd.tomb_capture = (st.mark == hrt_pkg::MARK_TOMB) && !st.have_tomb;
            cmd.probe_next   = 1'b1;
            state_next       = S_PRB_RD;
          end
        end else begin
          priority if (st.mark == hrt_pkg::MARK_EMPTY) begin
            state_next = S_DONE;
          end else if (st.mark == hrt_pkg::MARK_LIVE && st.key_match) begin
            cmd.wr       = hrt_pkg::WR_TOMB_POS;
            cmd.live_dec = 1'b1;
            cmd.res_take = 1'b1;
            if (st.live_one) begin
              clr_resp_next = 1'b1;
              state_next    = S_CLR;
            end else begin
              state_next = S_DONE;
            end
          end else if (st.n_last) begin
            state_next = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
            state_next     = S_PRB_RD;
          end
        end
      end
      S_EV_RD: begin
        cmd.scan   = 1'b1;
        state_next = S_EV_CHK;
      end
      S_EV_CHK: begin
        cmd.scan       = 1'b1;
        cmd.ev_capture = 1'b1;
        if (st.ev_last) begin
          state_next = S_EV_PUT;
        end else begin
          cmd.ev_next = 1'b1;
          state_next  = S_EV_RD;
        end
      end
      S_EV_PUT: begin
        cmd.wr      = hrt_pkg::WR_PUT_LOW;
        cmd.age_inc = 1'b1;
        cmd.res_ok  = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/hashed_reply_tracker_table_unit.sv @@
// ----------------------------------------------------------------------------
// hashed_reply_tracker_table_unit
// Key-to-value map in an open-addressed, linearly probed slot store.
// ----------------------------------------------------------------------------
// One request at a time. A request is accepted, decoded, hashed (three 32x32
// partial products on one multiplier) and mixed, and the home slot is taken
// from the low bits of the hash (the slot count is a power of two); then each
// slot probed is read and then checked, since the store has one registered
// read port, and at last the result is handed over. A record into a full
// table with no tombstone walks the whole store for the lowest age, reading
// and then checking each slot. Clear, and a take that leaves no live entry,
// wipe the store in a pass over every slot; the same pass runs after reset
// before the first request is taken.
// The result register frees the input side: a new request is accepted while
// the previous result still waits for out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_reply_tracker_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [63:0] lookup_key,
  input  wire logic [63:0] entry_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic      [63:0] taken_value
);

  hrt_pkg::cmd_t cmd;
  hrt_pkg::st_t  st;

  // sequencer: hash, probe, eviction scan, wipe pass
  hrt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  // slot store, arithmetic and result register
  hrt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .func       (func),
    .lookup_key (lookup_key),
    .entry_value(entry_value),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .ok         (ok),
    .taken_value(taken_value),
    .cmd        (cmd),
    .st         (st)
  );

`ifndef SYNTHESIS
  // one request in flight: acceptance closes the input for the next cycle
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // a failed request never returns a value
  a_no_value_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> taken_value == '0)
    else $error("value returned with ok low");

  // wipe pass holds off requests straight after reset
  a_wipe_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("request accepted before store wipe");

  // a result is only produced by a request that went through the input
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with the input idle");
`endif

endmodule

`default_nettype wire

@@ dv/hashed_reply_tracker_table_checker.sv @@
// ----------------------------------------------------------------------------
// hashed_reply_tracker_table_checker
// Watches both channels of the tracker table, keeps its own copy of the slot
// store, predicts the reply to each accepted request and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_reply_tracker_table_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [63:0] lookup_key,
  input  wire logic [63:0] entry_value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        ok,
  input  wire logic [63:0] taken_value,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        ok;
    logic [63:0] value;
  } reply_t;

  logic [63:0] keys   [hrt_pkg::TABLE_SLOTS];
  logic [63:0] vals   [hrt_pkg::TABLE_SLOTS];
  logic [63:0] ages   [hrt_pkg::TABLE_SLOTS];
  logic [1:0]  marks  [hrt_pkg::TABLE_SLOTS];
  int unsigned live_cnt;
  logic [63:0] age_now;
  reply_t      replies [$];

  assign pending = replies.size();

  function automatic int unsigned home_of(logic [63:0] k);
    logic [63:0] h;
    h = k ^ (k >> hrt_pkg::HASH_SHIFT);
    h = h * hrt_pkg::HASH_MUL;
    h = h ^ (h >> hrt_pkg::HASH_SHIFT);
    return int'(h % 64'(hrt_pkg::TABLE_SLOTS));
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < hrt_pkg::TABLE_SLOTS; i++) begin
      keys[i] = '0; vals[i] = '0; ages[i] = '0; marks[i] = hrt_pkg::MARK_EMPTY;
    end
  endfunction

  function automatic void put_pair(int unsigned at, logic [63:0] k, logic [63:0] v);
    keys[at] = k; vals[at] = v;
    age_now++;
    ages[at] = age_now;
    marks[at] = hrt_pkg::MARK_LIVE;
  endfunction

  function automatic logic record_pair(logic [63:0] k, logic [63:0] v);
    int unsigned pos, tomb, low;
    bit          seen_tomb;
    pos = home_of(k); tomb = 0; seen_tomb = 0;
    if (k == 0 || v == 0) return 1'b0;
    for (int n = 0; n < hrt_pkg::TABLE_SLOTS; n++) begin
      if (marks[pos] == hrt_pkg::MARK_LIVE) begin
        if (keys[pos] == k) begin
          vals[pos] = v;
          age_now++;
          ages[pos] = age_now;
          return 1'b1;
        end
      end else if (marks[pos] == hrt_pkg::MARK_TOMB) begin
        if (!seen_tomb) begin
          seen_tomb = 1; tomb = pos;
        end
      end else begin
        put_pair(seen_tomb ? tomb : pos, k, v);
        live_cnt++;
        return 1'b1;
      end
      pos = (pos + 1) % hrt_pkg::TABLE_SLOTS;
    end
    if (seen_tomb) begin
      put_pair(tomb, k, v);
      live_cnt++;
      return 1'b1;
    end
    // full store: oldest stamp goes, lower index on a tie
    low = 0;
    for (int n = 1; n < hrt_pkg::TABLE_SLOTS; n++)
      if (ages[n] < ages[low]) low = n;
    put_pair(low, k, v);
    return 1'b1;
  endfunction

  function automatic reply_t take_key(logic [63:0] k);
    reply_t      r;
    int unsigned pos;
    r.ok = 0; r.value = '0;
    pos = home_of(k);
    if (k == 0) return r;
    for (int n = 0; n < hrt_pkg::TABLE_SLOTS; n++) begin
      if (marks[pos] == hrt_pkg::MARK_EMPTY) return r;
      if (marks[pos] == hrt_pkg::MARK_LIVE && keys[pos] == k) begin
        r.ok = 1; r.value = vals[pos];
        keys[pos] = '0; vals[pos] = '0; ages[pos] = '0; marks[pos] = hrt_pkg::MARK_TOMB;
        if (live_cnt > 0) live_cnt--;
        if (live_cnt == 0) wipe_store();
        return r;
      end
      pos = (pos + 1) % hrt_pkg::TABLE_SLOTS;
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0; live_cnt = 0; age_now = '0;
    wipe_store();
  end

  always @(posedge clk) begin
    reply_t r, want;
    if (rst) begin
      wipe_store(); live_cnt = 0; age_now = '0; replies.delete();
    end else begin
      if (in_valid && in_ready) begin
        r.ok = 0; r.value = '0;
        case (func)
          hrt_pkg::FUNC_RECORD: r.ok = record_pair(lookup_key, entry_value);
          hrt_pkg::FUNC_TAKE:   r = take_key(lookup_key);
          hrt_pkg::FUNC_CLEAR: begin
            wipe_store(); live_cnt = 0; age_now = '0;
          end
          default: ;
        endcase
        replies.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (replies.size() == 0) begin
          report("unexpected reply", {63'd0, ok}, 64'd0);
        end else begin
          want = replies.pop_front();
          if (ok !== want.ok) report("ok", {63'd0, ok}, {63'd0, want.ok});
          if (taken_value !== want.value) report("taken_value", taken_value, want.value);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/hashed_reply_tracker_table_unit_tb.sv @@
// ----------------------------------------------------------------------------
// hashed_reply_tracker_table_unit_tb
// Drives record, take and clear requests into the tracker table under several
// idling mixes, with a long reply hold-off, a full-table eviction pass and a
// drain pause; the checker beside the block predicts and compares replies.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_reply_tracker_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 60000;   // eviction walk plus a long hold-off fits well inside
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  func = hrt_pkg::FUNC_RECORD;
  logic [63:0] lookup_key = '0;
  logic [63:0] entry_value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        ok;
  logic [63:0] taken_value;
  int          errors, pending;

  int          send_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  logic [63:0] key_pool [48];

  always #4 clk = ~clk;

  hashed_reply_tracker_table_unit uut (
    .clk, .rst, .in_valid, .in_ready, .func, .lookup_key, .entry_value,
    .out_valid, .out_ready, .ok, .taken_value
  );

  hashed_reply_tracker_table_checker chk (
    .clk, .rst, .in_valid, .in_ready, .func, .lookup_key, .entry_value,
    .out_valid, .out_ready, .ok, .taken_value, .errors, .pending
  );

  // reply side: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: nothing accepted on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("hashed_reply_tracker_table_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(logic [1:0] f, logic [63:0] k, logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f; lookup_key <= k; entry_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_request();
    int          pick;
    logic [63:0] k;
    pick = $urandom_range(99);
    k = key_pool[$urandom_range(47)];
    if (pick < 46)      send(hrt_pkg::FUNC_RECORD, k, rand64() | 64'd1);
    else if (pick < 82) send(hrt_pkg::FUNC_TAKE, k, rand64());
    else if (pick < 85) send(hrt_pkg::FUNC_CLEAR, rand64(), rand64());
    else if (pick < 89) send(FUNC_UNUSED, rand64(), rand64());
    else if (pick < 92) send(hrt_pkg::FUNC_RECORD, 64'd0, rand64());
    else if (pick < 95) send(hrt_pkg::FUNC_RECORD, k, 64'd0);
    else if (pick < 97) send(hrt_pkg::FUNC_TAKE, 64'd0, rand64());
    else                send(hrt_pkg::FUNC_RECORD, rand64(), rand64());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 48; i++) key_pool[i] = rand64();
    key_pool[0] = '1;
    key_pool[1] = 64'd1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every operation, zero key/value, spare code
    send(hrt_pkg::FUNC_RECORD, '1, '1);
    send(hrt_pkg::FUNC_RECORD, 64'd1, 64'd1);
    send(hrt_pkg::FUNC_RECORD, '1, 64'h8000_0000_0000_0000);   // update in place
    send(hrt_pkg::FUNC_TAKE, '1, '0);
    send(hrt_pkg::FUNC_TAKE, '1, '0);                          // miss past a tombstone
    send(hrt_pkg::FUNC_RECORD, 64'd0, 64'd5);
    send(hrt_pkg::FUNC_RECORD, 64'd7, 64'd0);
    send(hrt_pkg::FUNC_TAKE, 64'd0, '1);
    send(FUNC_UNUSED, '1, '1);
    send(hrt_pkg::FUNC_TAKE, 64'd1, '0);                       // last live entry: wiped
    send(hrt_pkg::FUNC_RECORD, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send(hrt_pkg::FUNC_RECORD, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send(hrt_pkg::FUNC_CLEAR, '1, '1);
    send(hrt_pkg::FUNC_TAKE, 64'h5555_5555_5555_5555, '0);

    // fill every slot, then force evictions and full-store probes
    for (int i = 0; i < hrt_pkg::TABLE_SLOTS; i++)
      send(hrt_pkg::FUNC_RECORD, {$urandom, 32'(i + 1)}, rand64() | 64'd1);
    send(hrt_pkg::FUNC_RECORD, {32'd0, 32'hffff_fff0}, 64'd3);
    send(hrt_pkg::FUNC_RECORD, {32'd0, 32'hffff_fff1}, 64'd4);
    send(hrt_pkg::FUNC_TAKE, {32'd0, 32'hffff_fff0}, '0);
    send(hrt_pkg::FUNC_TAKE, {32'd0, 32'hffff_ffff}, '0);
    send(hrt_pkg::FUNC_RECORD, {32'd0, 32'hffff_fff2}, 64'd6);
    send(hrt_pkg::FUNC_CLEAR, '0, '0);

    // random phases under the four idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 54) : 0;
      rx_stall_pct  = (phase == 2 || phase == 3) ? ((phase == 3) ? 26 : 54) : 0;
      for (int n = 0; n < 250; n++) begin
        if (phase == 0 && n == 100) hold_req = 400;   // input backs up behind held replies
        if (phase == 2 && n == 125) drain();          // sender waits for every reply
        random_request();
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("hashed_reply_tracker_table_unit verification clean");
    else
      $display("hashed_reply_tracker_table_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/hrt_pkg.sv
sv/hrt_ram.sv
sv/hrt_dp.sv
sv/hrt_ctrl.sv
sv/hashed_reply_tracker_table_unit.sv
dv/hashed_reply_tracker_table_checker.sv
dv/hashed_reply_tracker_table_unit_tb.sv
